>>> design/lru2_pkg.sv
// Package: shared types, constants and command/status codes of the LRU-2 page table.
package lru2_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int ID_BITS    = 32;
  localparam int STAMP_BITS = 32;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  localparam logic [2:0] CMD_FETCH   = 3'd0;
  localparam logic [2:0] CMD_UNPIN   = 3'd1;
  localparam logic [2:0] CMD_RENAME  = 3'd2;
  localparam logic [2:0] CMD_DISCARD = 3'd3;
  localparam logic [2:0] CMD_TRIM    = 3'd4;

  localparam logic [3:0] ST_HIT       = 4'd0;
  localparam logic [3:0] ST_ALLOC     = 4'd1;
  localparam logic [3:0] ST_EVICT     = 4'd2;
  localparam logic [3:0] ST_MISS      = 4'd3;
  localparam logic [3:0] ST_ALLPIN    = 4'd4;
  localparam logic [3:0] ST_UNPINNED  = 4'd5;
  localparam logic [3:0] ST_DROPPED   = 4'd6;
  localparam logic [3:0] ST_NOTFOUND  = 4'd7;
  localparam logic [3:0] ST_DONE      = 4'd8;

  // scan kinds run by the datapath
  typedef enum logic [2:0] {
    SCAN_FIND    = 3'd0,
    SCAN_VICTIM  = 3'd1,
    SCAN_RENAME  = 3'd2,
    SCAN_DISCARD = 3'd3,
    SCAN_TRIM    = 3'd4
  } scan_kind_t;

  // final action applied at the end of a command
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PIN    = 3'd1,
    ACT_FILL   = 3'd2,
    ACT_UNPIN  = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_RENAME = 3'd5
  } act_t;

  typedef struct packed {
    logic       load;       // capture input item, clear scan results
    logic       scan_start; // reset scan index
    logic       scan_step;  // visit one slot
    scan_kind_t kind;
    logic       apply;      // apply action to target slot
    act_t       act;
    logic       use_victim; // target is victim instead of found slot
    logic       bump_fetch;
    logic       bump_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic             scan_last;
    logic             found;
    logic             victim_ok;
    logic             free_ok;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

endpackage

>>> design/lru2_datapath.sv
// Datapath: slot arrays, one-slot-per-cycle scan unit, counters and result fields.
module lru2_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lru2_pkg::dp_cmd_t             cmd,
  output lru2_pkg::dp_stat_t            stat,
  input  logic [lru2_pkg::ID_BITS-1:0]  in_pid,
  input  logic [lru2_pkg::ID_BITS-1:0]  in_npid,
  input  logic [lru2_pkg::CNT_W-1:0]    max_pages,
  output logic [lru2_pkg::IDX_W-1:0]    slot_o,
  output logic [lru2_pkg::ID_BITS-1:0]  ev_id_o,
  output logic [lru2_pkg::CNT_W-1:0]    removed_o,
  output logic [31:0]                   fetch_total_o,
  output logic [31:0]                   hit_total_o
);
  localparam int IW = lru2_pkg::IDX_W;
  localparam int CW = lru2_pkg::CNT_W;
  localparam int SW = lru2_pkg::STAMP_BITS;

  logic [lru2_pkg::ENTRIES-1:0]     valid_r;
  logic [lru2_pkg::ID_BITS-1:0]     page_r  [lru2_pkg::ENTRIES];
  logic [lru2_pkg::ENTRIES-1:0]     pinned_r;
  logic [SW-1:0]                    last_r  [lru2_pkg::ENTRIES];
  logic [SW-1:0]                    prior_r [lru2_pkg::ENTRIES];
  logic [SW-1:0]                    stamp_r;
  logic [31:0]                      fetch_r, hit_r;
  logic [CW-1:0]                    count_r;

  logic [lru2_pkg::ID_BITS-1:0]     pid_r, npid_r;
  logic [IW-1:0]                    idx_r;
  logic                             found_r;
  logic [IW-1:0]                    found_idx_r;
  logic                             one_ok_r, two_ok_r;
  logic [IW-1:0]                    one_idx_r, two_idx_r;
  logic [SW-1:0]                    one_st_r, two_st_r;
  logic                             free_ok_r;
  logic [IW-1:0]                    free_idx_r;
  logic [CW-1:0]                    removed_r;
  logic [CW-1:0]                    trim_n_r;

  logic [IW-1:0] tgt;
  logic          cur_v, cur_p;
  logic [SW-1:0] cur_last, cur_prior;
  logic [lru2_pkg::ID_BITS-1:0] cur_page;

  assign cur_v     = valid_r[idx_r];
  assign cur_p     = pinned_r[idx_r];
  assign cur_page  = page_r[idx_r];
  assign cur_last  = last_r[idx_r];
  assign cur_prior = prior_r[idx_r];

  assign tgt = cmd.use_victim ? (one_ok_r ? one_idx_r : two_idx_r)
             : (free_ok_r && cmd.act == lru2_pkg::ACT_FILL ? free_idx_r : found_idx_r);

  assign stat.scan_last = (idx_r == IW'(lru2_pkg::ENTRIES - 1));
  assign stat.found     = found_r;
  assign stat.victim_ok = one_ok_r | two_ok_r;
  assign stat.free_ok   = free_ok_r;
  assign stat.count     = count_r;

  assign removed_o     = removed_r;
  assign fetch_total_o = fetch_r;
  assign hit_total_o   = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      stamp_r <= SW'(1);
      fetch_r <= '0;
      hit_r   <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.bump_fetch) fetch_r <= fetch_r + 32'd1;
      if (cmd.bump_hit)   hit_r   <= hit_r + 32'd1;
      if (cmd.load) begin
        pid_r     <= in_pid;
        npid_r    <= in_npid;
        found_r   <= 1'b0;
        one_ok_r  <= 1'b0;
        two_ok_r  <= 1'b0;
        free_ok_r <= 1'b0;
        removed_r <= '0;
        trim_n_r  <= count_r;
        slot_o    <= '0;
        ev_id_o   <= '0;
      end
      if (cmd.scan_start) idx_r <= '0;
      if (cmd.scan_step) begin
        idx_r <= idx_r + IW'(1);
        unique case (cmd.kind)
          lru2_pkg::SCAN_FIND: begin
            if (cur_v && cur_page == pid_r && !found_r) begin
              found_r     <= 1'b1;
              found_idx_r <= idx_r;
            end
            if (!cur_v && !free_ok_r) begin
              free_ok_r  <= 1'b1;
              free_idx_r <= idx_r;
            end
          end
          lru2_pkg::SCAN_VICTIM: begin
            if (cur_v && !cur_p) begin
              if (cur_prior == '0) begin
                if (!one_ok_r || cur_last < one_st_r) begin
                  one_ok_r <= 1'b1; one_idx_r <= idx_r; one_st_r <= cur_last;
                end
              end else if (!two_ok_r || cur_prior < two_st_r) begin
                two_ok_r <= 1'b1; two_idx_r <= idx_r; two_st_r <= cur_prior;
              end
            end
          end
          lru2_pkg::SCAN_RENAME: begin
            if (idx_r != found_idx_r && cur_v && cur_page == npid_r) begin
              valid_r[idx_r] <= 1'b0;
              removed_r      <= removed_r + CW'(1);
              count_r        <= count_r - CW'(1);
            end
          end
          lru2_pkg::SCAN_DISCARD: begin
            if (cur_v && cur_page >= pid_r) begin
              valid_r[idx_r] <= 1'b0;
              removed_r      <= removed_r + CW'(1);
              count_r        <= count_r - CW'(1);
            end
          end
          lru2_pkg::SCAN_TRIM: begin
            if (cur_v && !cur_p && trim_n_r > max_pages) begin
              valid_r[idx_r] <= 1'b0;
              removed_r      <= removed_r + CW'(1);
              count_r        <= count_r - CW'(1);
              trim_n_r       <= trim_n_r - CW'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.apply) begin
        case (cmd.act)
          lru2_pkg::ACT_PIN: begin
            pinned_r[tgt] <= 1'b1;
            slot_o        <= tgt;
          end
          lru2_pkg::ACT_FILL: begin
            if (cmd.use_victim) ev_id_o <= page_r[tgt];
            else count_r <= count_r + CW'(1);
            valid_r[tgt]  <= 1'b1;
            page_r[tgt]   <= pid_r;
            pinned_r[tgt] <= 1'b1;
            last_r[tgt]   <= '0;
            prior_r[tgt]  <= '0;
            slot_o        <= tgt;
          end
          lru2_pkg::ACT_UNPIN: begin
            pinned_r[tgt] <= 1'b0;
            if (last_r[tgt] != '0) prior_r[tgt] <= last_r[tgt];
            last_r[tgt] <= stamp_r;
            if (stamp_r != lru2_pkg::STAMP_MAX) stamp_r <= stamp_r + SW'(1);
          end
          lru2_pkg::ACT_REMOVE: begin
            valid_r[tgt] <= 1'b0;
            count_r      <= count_r - CW'(1);
          end
          lru2_pkg::ACT_RENAME: page_r[tgt] <= npid_r;
          default: ;
        endcase
      end
    end
  end
endmodule

>>> design/lru2_ctrl.sv
// Controller: command sequencing state machine, output register and handshakes.
module lru2_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [2:0]                 in_cmd,
  input  logic                       in_alloc,
  input  logic                       in_drop,
  input  logic [lru2_pkg::CNT_W-1:0] max_pages,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3:0]                 status_o,
  output logic                       ev_valid_o,
  output lru2_pkg::dp_cmd_t          cmd,
  input  lru2_pkg::dp_stat_t         stat
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_DEC   = 6'b000100,
    S_SCAN2 = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cmd_r;
  logic alloc_r, drop_r;
  logic [3:0] status_r, status_nxt;
  logic ev_r, ev_nxt;
  logic [lru2_pkg::CNT_W-1:0] limit;

  assign limit = (max_pages > lru2_pkg::CNT_W'(lru2_pkg::ENTRIES)) ?
                 lru2_pkg::CNT_W'(lru2_pkg::ENTRIES) : max_pages;
  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign status_o   = status_r;
  assign ev_valid_o = ev_r;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    ev_nxt     = ev_r;
    cmd        = '0;
    cmd.kind   = lru2_pkg::SCAN_FIND;
    cmd.act    = lru2_pkg::ACT_NONE;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load       = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.bump_fetch = (in_cmd == lru2_pkg::CMD_FETCH);
        status_nxt     = lru2_pkg::ST_DONE;
        ev_nxt         = 1'b0;
        state_nxt      = S_FIND;
      end
      S_FIND: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_OUT;
        case (cmd_r)
          lru2_pkg::CMD_FETCH:
            if (stat.found) begin
              cmd.apply = 1'b1; cmd.act = lru2_pkg::ACT_PIN; cmd.bump_hit = 1'b1;
              status_nxt = lru2_pkg::ST_HIT;
            end else if (!alloc_r) status_nxt = lru2_pkg::ST_MISS;
            else if (stat.count < limit) begin
              if (stat.free_ok) begin
                cmd.apply = 1'b1; cmd.act = lru2_pkg::ACT_FILL;
                status_nxt = lru2_pkg::ST_ALLOC;
              end
            end else begin
              cmd.kind = lru2_pkg::SCAN_VICTIM; state_nxt = S_SCAN2;
            end
          lru2_pkg::CMD_UNPIN:
            if (!stat.found) status_nxt = lru2_pkg::ST_NOTFOUND;
            else if (drop_r || stat.count > max_pages) begin
              cmd.apply = 1'b1; cmd.act = lru2_pkg::ACT_REMOVE;
              status_nxt = lru2_pkg::ST_DROPPED;
            end else begin
              cmd.apply = 1'b1; cmd.act = lru2_pkg::ACT_UNPIN;
              status_nxt = lru2_pkg::ST_UNPINNED;
            end
          lru2_pkg::CMD_RENAME:
            if (!stat.found) status_nxt = lru2_pkg::ST_NOTFOUND;
            else state_nxt = S_SCAN2;
          lru2_pkg::CMD_DISCARD, lru2_pkg::CMD_TRIM: state_nxt = S_SCAN2;
          default: ;
        endcase
      end
      S_SCAN2: begin
        cmd.scan_step = 1'b1;
        case (cmd_r)
          lru2_pkg::CMD_FETCH:   cmd.kind = lru2_pkg::SCAN_VICTIM;
          lru2_pkg::CMD_RENAME:  cmd.kind = lru2_pkg::SCAN_RENAME;
          lru2_pkg::CMD_DISCARD: cmd.kind = lru2_pkg::SCAN_DISCARD;
          default:               cmd.kind = lru2_pkg::SCAN_TRIM;
        endcase
        if (stat.scan_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_OUT;
        if (cmd_r == lru2_pkg::CMD_FETCH) begin
          if (stat.victim_ok) begin
            cmd.apply = 1'b1; cmd.act = lru2_pkg::ACT_FILL; cmd.use_victim = 1'b1;
            status_nxt = lru2_pkg::ST_EVICT; ev_nxt = 1'b1;
          end else status_nxt = lru2_pkg::ST_ALLPIN;
        end else if (cmd_r == lru2_pkg::CMD_RENAME) begin
          cmd.apply = 1'b1; cmd.act = lru2_pkg::ACT_RENAME;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    status_r <= status_nxt;
    ev_r     <= ev_nxt;
    if (in_fire) begin
      cmd_r   <= in_cmd;
      alloc_r <= in_alloc;
      drop_r  <= in_drop;
    end
  end
endmodule

>>> design/lru2_page_table.sv
// Top level: LRU-2 page table with stream input/output and a page-limit register.
//
// Usage:
//  - in_* channel carries one command per transfer (fetch, unpin, rename,
//    discard at or above a limit, trim to the page limit).
//  - out_* channel returns exactly one result transfer per command.
//  - cfg_we/cfg_wdata write max_pages (reset 16); write only while idle.
// Timing:
//  - One command at a time. A lookup pass visits the 16 slots one per cycle,
//    then a decide state; fetch-with-eviction, rename of a present page,
//    discard and trim run a second pass over the 16 slots plus a finish
//    state. With out_tready high the block returns to idle after the result
//    transfer and can take the next command.
//  - in_tready is high only while no command is in flight.
// Reset: all slots invalid, stamp counter 1, fetch/hit totals 0.
// Stall: the result holds in its register until out_tready; no new command
//  is accepted meanwhile.
module lru2_page_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: cmd[2:0], page_id[34:3], new_page_id[66:35], zero fill to 72
  input  logic [71:0]  in_tdata,
  // tuser: allocate[0], drop_page[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: status[3:0], slot[7:4], evicted_valid[8], evicted_id[40:9],
  // removed_count[45:41], page_count[50:46], fetch_total[82:51],
  // hit_total[114:83], zero fill to 120
  output logic [119:0] out_tdata,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata
);
  logic [4:0]          max_pages_r;
  logic                busy, in_fire, ev_valid;
  logic [3:0]          status;
  logic [3:0]          slot;
  logic [31:0]         ev_id, fetch_total, hit_total;
  logic [4:0]          removed;
  lru2_pkg::dp_cmd_t   dcmd;
  lru2_pkg::dp_stat_t  dstat;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pages_r <= 5'd16;
    end else if (cfg_we) begin
      max_pages_r <= cfg_wdata;
    end
  end

  lru2_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_cmd    (in_tdata[2:0]),
    .in_alloc  (in_tuser[0]),
    .in_drop   (in_tuser[1]),
    .max_pages (max_pages_r),
    .busy,
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status_o  (status),
    .ev_valid_o(ev_valid),
    .cmd       (dcmd),
    .stat      (dstat)
  );

  lru2_datapath u_dp (
    .clk, .rst_n,
    .cmd          (dcmd),
    .stat         (dstat),
    .in_pid       (in_tdata[34:3]),
    .in_npid      (in_tdata[66:35]),
    .max_pages    (max_pages_r),
    .slot_o       (slot),
    .ev_id_o      (ev_id),
    .removed_o    (removed),
    .fetch_total_o(fetch_total),
    .hit_total_o  (hit_total)
  );

  assign out_tdata = {5'd0, hit_total, fetch_total, dstat.count, removed,
                      ev_id, ev_valid, slot, status};
endmodule

>>> sim/lru2_checker.sv
// Checker: watches the command and result streams, predicts each result and compares.
module lru2_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [71:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  output int           fail_count,
  output int           results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE = lru2_pkg::ENTRIES;
  localparam int IW = lru2_pkg::IDX_W;
  localparam int CW = lru2_pkg::CNT_W;
  localparam int DW = lru2_pkg::ID_BITS;
  localparam int SW = lru2_pkg::STAMP_BITS;

  typedef struct packed {
    logic [3:0]            status;
    logic [IW-1:0]         slot;
    logic                  ev_valid;
    logic [DW-1:0]         ev_id;
    logic [CW-1:0]         removed;
    logic [CW-1:0]         pages;
    logic [31:0]           fetches;
    logic [31:0]           hits;
  } table_result_t;

  // shadow of the page table
  logic                  sh_valid  [NE];
  logic [DW-1:0]         sh_page   [NE];
  logic                  sh_pinned [NE];
  logic [SW-1:0]         sh_last   [NE];
  logic [SW-1:0]         sh_prior  [NE];
  logic [SW-1:0]         sh_stamp;
  logic [31:0]           sh_fetches, sh_hits;
  logic [4:0]            sh_limit;

  table_result_t due_results[$];

  function automatic int live_pages();
    int n;
    n = 0;
    for (int i = 0; i < NE; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  function automatic int find_slot(logic [DW-1:0] id);
    for (int i = 0; i < NE; i++) if (sh_valid[i] && sh_page[i] == id) return i;
    return -1;
  endfunction

  function automatic void claim_slot(int i, logic [DW-1:0] id);
    sh_valid[i]  = 1'b1;
    sh_page[i]   = id;
    sh_pinned[i] = 1'b1;
    sh_last[i]   = '0;
    sh_prior[i]  = '0;
  endfunction

  // runs one command against the shadow table, returns its result
  function automatic table_result_t run_command(logic [2:0] cmd, logic [DW-1:0] pid,
                                                logic [DW-1:0] npid, logic alloc,
                                                logic drop);
    table_result_t r;
    int s, f, one, two, v, n, cap;
    r = '0;
    r.status = lru2_pkg::ST_DONE;
    case (cmd)
      lru2_pkg::CMD_FETCH: begin
        sh_fetches++;
        s = find_slot(pid);
        if (s >= 0) begin
          sh_hits++;
          sh_pinned[s] = 1'b1;
          r.status = lru2_pkg::ST_HIT;
          r.slot = IW'(s);
        end else if (!alloc) begin
          r.status = lru2_pkg::ST_MISS;
        end else begin
          cap = (sh_limit < NE) ? int'(sh_limit) : NE;
          if (live_pages() < cap) begin
            f = -1;
            for (int i = 0; i < NE && f < 0; i++) if (!sh_valid[i]) f = i;
            claim_slot(f, pid);
            r.status = lru2_pkg::ST_ALLOC;
            r.slot = IW'(f);
          end else begin
            // single-unpin pages first by last stamp, else oldest prior stamp
            one = -1;
            two = -1;
            for (int i = 0; i < NE; i++) begin
              if (!sh_valid[i] || sh_pinned[i]) continue;
              if (sh_prior[i] == 0) begin
                if (one < 0 || sh_last[i] < sh_last[one]) one = i;
              end else begin
                if (two < 0 || sh_prior[i] < sh_prior[two]) two = i;
              end
            end
            v = (one >= 0) ? one : two;
            if (v < 0) begin
              r.status = lru2_pkg::ST_ALLPIN;
            end else begin
              r.ev_valid = 1'b1;
              r.ev_id = sh_page[v];
              claim_slot(v, pid);
              r.status = lru2_pkg::ST_EVICT;
              r.slot = IW'(v);
            end
          end
        end
      end
      lru2_pkg::CMD_UNPIN: begin
        s = find_slot(pid);
        if (s < 0) begin
          r.status = lru2_pkg::ST_NOTFOUND;
        end else if (drop || live_pages() > sh_limit) begin
          sh_valid[s] = 1'b0;
          r.status = lru2_pkg::ST_DROPPED;
        end else begin
          sh_pinned[s] = 1'b0;
          if (sh_last[s] != 0) sh_prior[s] = sh_last[s];
          sh_last[s] = sh_stamp;
          if (sh_stamp != lru2_pkg::STAMP_MAX) sh_stamp++;
          r.status = lru2_pkg::ST_UNPINNED;
        end
      end
      lru2_pkg::CMD_RENAME: begin
        s = find_slot(pid);
        if (s < 0) begin
          r.status = lru2_pkg::ST_NOTFOUND;
        end else begin
          for (int i = 0; i < NE; i++)
            if (i != s && sh_valid[i] && sh_page[i] == npid) begin
              sh_valid[i] = 1'b0;
              r.removed++;
            end
          sh_page[s] = npid;
        end
      end
      lru2_pkg::CMD_DISCARD: begin
        for (int i = 0; i < NE; i++)
          if (sh_valid[i] && sh_page[i] >= pid) begin
            sh_valid[i] = 1'b0;
            r.removed++;
          end
      end
      lru2_pkg::CMD_TRIM: begin
        n = live_pages();
        for (int i = 0; i < NE && n > sh_limit; i++)
          if (sh_valid[i] && !sh_pinned[i]) begin
            sh_valid[i] = 1'b0;
            r.removed++;
            n--;
          end
      end
      default: ;
    endcase
    r.pages = CW'(live_pages());
    r.fetches = sh_fetches;
    r.hits = sh_hits;
    return r;
  endfunction

  table_result_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NE; i++) sh_valid[i] = 1'b0;
      sh_stamp = SW'(1);
      sh_fetches = '0;
      sh_hits = '0;
      sh_limit = 5'd16;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) sh_limit = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got.status   = out_tdata[3:0];
        got.slot     = out_tdata[7:4];
        got.ev_valid = out_tdata[8];
        got.ev_id    = out_tdata[40:9];
        got.removed  = out_tdata[45:41];
        got.pages    = out_tdata[50:46];
        got.fetches  = out_tdata[82:51];
        got.hits     = out_tdata[114:83];
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result transfer with nothing due: %p", got);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.ev_valid !== want.ev_valid || got.ev_id !== want.ev_id ||
              got.removed !== want.removed || got.pages !== want.pages ||
              got.fetches !== want.fetches || got.hits !== want.hits) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        due_results.push_back(run_command(in_tdata[2:0], in_tdata[34:3], in_tdata[66:35],
                                          in_tuser[0], in_tuser[1]));
    end
    results_due = due_results.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;   // cmd, page_id, new_page_id, zero fill
  logic [1:0]   in_tuser = '0;   // allocate, drop_page
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;       // status .. hit_total, see dut ports
  logic         cfg_we = 1'b0;
  logic [4:0]   cfg_wdata = '0;

  int fail_count, results_due;
  int sent = 0;
  bit calm = 1'b0;    // no idling on either side while set
  bit hold_off = 1'b0; // receiver parked
  logic [lru2_pkg::ID_BITS-1:0] id_pool [20];

  always #5 clk = ~clk;

  lru2_page_table dut (.*);

  lru2_checker checker_i (.*);

  // receiver: random stalls, forced low while parked
  always @(posedge clk)
    out_tready <= hold_off ? 1'b0 : (calm || $urandom_range(99) >= 37);

  // long receiver hold-off so the next command waits behind the pending result
  initial begin
    wait (sent == 300);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // one command transfer; valid stays high into the next call when there is no gap
  task automatic send_cmd(logic [2:0] cmd, logic [lru2_pkg::ID_BITS-1:0] pid,
                          logic [lru2_pkg::ID_BITS-1:0] npid, logic alloc, logic drop);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, npid, pid, cmd};
    in_tuser  <= {drop, alloc};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // write the page limit once the table is quiet
  task automatic set_limit(logic [4:0] lim);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [lru2_pkg::ID_BITS-1:0] pick_id();
    return ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(19)];
  endfunction

  task automatic random_cmd();
    int w;
    w = $urandom_range(99);
    if (w < 45)      send_cmd(lru2_pkg::CMD_FETCH, pick_id(), $urandom,
                              $urandom_range(99) < 85, $urandom_range(1));
    else if (w < 80) send_cmd(lru2_pkg::CMD_UNPIN, pick_id(), $urandom,
                              $urandom_range(1), $urandom_range(9) == 0);
    else if (w < 87) send_cmd(lru2_pkg::CMD_RENAME, pick_id(), pick_id(),
                              $urandom_range(1), $urandom_range(1));
    else if (w < 91) send_cmd(lru2_pkg::CMD_DISCARD, pick_id(), $urandom,
                              $urandom_range(1), $urandom_range(1));
    else if (w < 96) send_cmd(lru2_pkg::CMD_TRIM, $urandom, $urandom,
                              $urandom_range(1), $urandom_range(1));
    else             send_cmd(3'($urandom_range(7, 5)), $urandom, $urandom,
                              $urandom_range(1), $urandom_range(1));
  endtask

  logic [4:0] limits [7] = '{5'd16, 5'd0, 5'd3, 5'd8, 5'd31, 5'd12, 5'd16};

  initial begin
    for (int i = 0; i < 20; i++) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each command and its corner cases
    send_cmd(lru2_pkg::CMD_FETCH, '0, '0, 1'b1, 1'b0);          // allocate id zero
    send_cmd(lru2_pkg::CMD_FETCH, '1, '1, 1'b1, 1'b1);          // allocate all-ones id
    send_cmd(lru2_pkg::CMD_FETCH, 32'h5, '0, 1'b0, 1'b0);       // miss, no allocation
    send_cmd(lru2_pkg::CMD_FETCH, '0, '0, 1'b0, 1'b0);          // hit
    send_cmd(lru2_pkg::CMD_UNPIN, '0, '0, 1'b0, 1'b0);          // first stamp
    send_cmd(lru2_pkg::CMD_UNPIN, '0, '0, 1'b0, 1'b0);          // unpin of an unpinned page
    send_cmd(lru2_pkg::CMD_UNPIN, 32'h77, '0, 1'b0, 1'b0);      // absent page
    send_cmd(lru2_pkg::CMD_RENAME, 32'h99, 32'h1, 1'b0, 1'b0);  // rename absent
    send_cmd(lru2_pkg::CMD_RENAME, '0, '1, 1'b0, 1'b0);         // rename onto existing id
    send_cmd(lru2_pkg::CMD_RENAME, '1, 32'h10, 1'b0, 1'b0);     // plain rename
    send_cmd(lru2_pkg::CMD_UNPIN, 32'h10, '0, 1'b0, 1'b1);      // unpin with drop
    for (int i = 0; i < 8; i++)
      send_cmd(lru2_pkg::CMD_FETCH, 32'h100 + i, '0, 1'b1, 1'b0);
    send_cmd(lru2_pkg::CMD_UNPIN, 32'h102, '0, 1'b0, 1'b0);
    send_cmd(lru2_pkg::CMD_DISCARD, 32'h106, '0, 1'b0, 1'b0);   // removes pinned pages too
    send_cmd(lru2_pkg::CMD_TRIM, '0, '0, 1'b0, 1'b0);
    send_cmd(3'd5, '0, '0, 1'b0, 1'b0);                         // unused codes
    send_cmd(3'd7, '1, '1, 1'b1, 1'b1);

    // random phases across page limits, one quiet stretch in the middle
    foreach (limits[p]) begin
      set_limit(limits[p]);
      for (int k = 0; k < 230; k++) begin
        calm = (p == 3);
        random_cmd();
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    wait (results_due == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && results_due == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
